@@ rtl/hhlp_pkg.sv @@
// hhlp_pkg: shared types and constants for the HTTP header line parser.
// Parse states, byte tags, character codes and the classifier structs.
// No dependencies.
package hhlp_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 9;
    localparam int unsigned KindW  = 3;

    localparam logic [CountW-1:0] MaxValueLenReset = 9'd256;

    localparam logic [ByteW-1:0] ChColon = 8'h3A;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;

    typedef enum logic [3:0] {
        ST_START = 4'd0,
        ST_KEY   = 4'd1,
        ST_COLON = 4'd2,
        ST_SPACE = 4'd3,
        ST_VALUE = 4'd4,
        ST_VCR   = 4'd5,
        ST_LINE  = 4'd6,
        ST_ENDCR = 4'd7,
        ST_BODY  = 4'd8,
        ST_ERROR = 4'd9
    } t_parse_state;

    typedef enum logic [KindW-1:0] {
        K_SKIP  = 3'd0,
        K_KEY   = 3'd1,
        K_COLON = 3'd2,
        K_VALUE = 3'd3,
        K_PAIR  = 3'd4,
        K_END   = 3'd5,
        K_ERR   = 3'd6,
        K_BODY  = 3'd7
    } t_kind;

    typedef struct packed {
        t_parse_state       state;
        logic [CountW-1:0]  count;
        logic               err;
    } t_parse_ctx;

    typedef struct packed {
        t_parse_ctx ctx;
        t_kind      kind;
    } t_cls_result;

endpackage

@@ rtl/hhlp_classify.sv @@
// hhlp_classify: combinational byte classifier and next-state logic.
// Given the parse context and one byte, yields the tag and the new context.
// Depends on hhlp_pkg.
module hhlp_classify (
    input  hhlp_pkg::t_parse_ctx           i_ctx,
    input  logic [hhlp_pkg::CountW-1:0]    i_max_len,
    input  logic [hhlp_pkg::ByteW-1:0]     i_byte,
    input  logic                           i_restart,
    output hhlp_pkg::t_cls_result          o_result
);
    import hhlp_pkg::*;

    t_parse_ctx cur;
    t_parse_ctx nxt;
    t_kind      kind;
    logic       is_cr;
    logic       is_lf;

    assign is_cr = (i_byte == ChCr);
    assign is_lf = (i_byte == ChLf);

    always_comb begin
        cur = i_ctx;
        if (i_restart) begin
            cur.state = ST_START;
            cur.count = '0;
            cur.err   = 1'b0;
        end
        nxt  = cur;
        kind = K_ERR;
        unique case (cur.state)
            ST_START: begin
                if (is_cr || is_lf) begin
                    kind = K_SKIP;
                end else begin
                    nxt.state = ST_KEY;
                    kind      = K_KEY;
                end
            end
            ST_KEY: begin
                if (i_byte == ChColon) begin
                    nxt.state = ST_COLON;
                    kind      = K_COLON;
                end else if (is_cr || is_lf) begin
                    nxt.state = ST_ERROR;
                    nxt.err   = 1'b1;
                end else begin
                    kind = K_KEY;
                end
            end
            ST_COLON: begin
                if (i_byte == ChSpace) begin
                    nxt.state = ST_SPACE;
                    kind      = K_COLON;
                end else begin
                    nxt.state = ST_ERROR;
                    nxt.err   = 1'b1;
                end
            end
            ST_SPACE: begin
                nxt.state = ST_VALUE;
                nxt.count = CountW'(1);
                kind      = K_VALUE;
            end
            ST_VALUE: begin
                if (is_cr) begin
                    nxt.state = ST_VCR;
                    kind      = K_SKIP;
                end else if (cur.count >= i_max_len) begin
                    nxt.state = ST_ERROR;
                    nxt.err   = 1'b1;
                end else begin
                    nxt.count = cur.count + CountW'(1);
                    kind      = K_VALUE;
                end
            end
            ST_VCR: begin
                if (is_lf) begin
                    nxt.state = ST_LINE;
                    nxt.count = '0;
                    kind      = K_PAIR;
                end else begin
                    nxt.state = ST_ERROR;
                    nxt.err   = 1'b1;
                end
            end
            ST_LINE: begin
                if (is_cr) begin
                    nxt.state = ST_ENDCR;
                    kind      = K_SKIP;
                end else begin
                    nxt.state = ST_KEY;
                    kind      = K_KEY;
                end
            end
            ST_ENDCR: begin
                if (is_lf) begin
                    nxt.state = ST_BODY;
                    kind      = K_END;
                end else begin
                    nxt.state = ST_ERROR;
                    nxt.err   = 1'b1;
                end
            end
            ST_BODY: begin
                kind = K_BODY;
            end
            default: begin
                // error state and unused codes
                nxt.state = ST_ERROR;
                nxt.err   = 1'b1;
            end
        endcase
    end

    assign o_result.ctx  = nxt;
    assign o_result.kind = kind;

endmodule

@@ rtl/http_header_line_parser_unit.sv @@
// http_header_line_parser_unit: top level of the HTTP header line parser.
// Input register, classifier and result register with stream handshakes.
// Depends on hhlp_pkg and hhlp_classify.

// Tags each header byte (key, colon, value, pair done, headers end, error,
// body or skipped) at one byte per clock while the output side keeps up. A
// transaction is held in an input register, classified combinationally by
// hhlp_classify against the parse state, value counter and sticky error, and
// the tag is written to the result register; the parse state advances as the
// transaction moves across. tuser bit 0 on the input restarts the parser
// before that byte. The value length limit is written through i_cfg_wr_en;
// the user must write it only while idle; the block does not enforce this.
module http_header_line_parser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [hhlp_pkg::CountW-1:0]   i_cfg_wr_data,  // max_value_len
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] byte_in
    input  logic                          s_axis_tuser,   // [0] restart
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] byte_out
    output logic [3:0]                    m_axis_tuser    // [2:0] kind, [3] error_flag
);
    import hhlp_pkg::*;

    logic                r_in_valid;
    logic [ByteW-1:0]    r_in_byte;
    logic                r_in_restart;
    logic                r_out_valid;
    logic [ByteW-1:0]    r_out_byte;
    t_kind               r_out_kind;
    logic                r_out_err;
    t_parse_ctx          r_ctx;
    logic [CountW-1:0]   r_max_len;
    t_cls_result         cls;
    logic                advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    hhlp_classify u_classify (
        .i_ctx     (r_ctx),
        .i_max_len (r_max_len),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_result  (cls)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx.state <= ST_START;
            r_ctx.count <= '0;
            r_ctx.err   <= 1'b0;
            r_max_len   <= MaxValueLenReset;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= cls.ctx;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte    <= s_axis_tdata;
            r_in_restart <= s_axis_tuser;
        end
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out_kind <= cls.kind;
            r_out_err  <= cls.ctx.err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = {r_out_err, r_out_kind};

endmodule
